### rtl/core/mlpt_pkg.sv
// Shared types for the perceptron inference block.
package mlpt_pkg;

  typedef enum logic [1:0] {
    L_ONE = 2'd0,
    L_TWO = 2'd1,
    L_OUT = 2'd2
  } layer_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic bias;
  } mac_ctrl_t;

  localparam int FRAC_BITS  = 12;
  localparam int FULL_SCALE = 32767;

endpackage

### rtl/core/mlpt_wstore.sv
// Weight and bias store: one write port, one registered read port.
module mlpt_wstore #(
  parameter int DEPTH = 5896,
  parameter int AW    = 13
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [15:0]   wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [15:0]   rd_data_r
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

### rtl/core/mlpt_abuf.sv
// Feature buffer and the two hidden-layer activation buffers.
module mlpt_abuf #(
  parameter int INPUT_COUNT  = 18,
  parameter int HIDDEN_COUNT = 64,
  parameter int JW           = 7,
  parameter int NW           = 7
) (
  input  logic                 clk,
  input  mlpt_pkg::layer_t     layer,
  input  logic [JW-1:0]        rd_addr,
  output logic signed [15:0]   rd_data_r,
  input  logic                 feat_wr,
  input  logic [12:0]          feat_addr,
  input  logic signed [15:0]   feat_data,
  input  logic                 hid_wr,
  input  logic [NW-1:0]        hid_addr,
  input  logic signed [15:0]   hid_data
);

  localparam int FW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int HW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;

  logic signed [15:0] feat_mem [INPUT_COUNT];
  logic signed [15:0] h1_mem [HIDDEN_COUNT];
  logic signed [15:0] h2_mem [HIDDEN_COUNT];

  always_ff @(posedge clk) begin
    if (feat_wr && (32'(feat_addr) < INPUT_COUNT)) begin
      feat_mem[FW'(feat_addr)] <= feat_data;
    end
    if (hid_wr && (layer == mlpt_pkg::L_ONE)) begin
      h1_mem[hid_addr[HW-1:0]] <= hid_data;
    end
    if (hid_wr && (layer == mlpt_pkg::L_TWO)) begin
      h2_mem[hid_addr[HW-1:0]] <= hid_data;
    end
    case (layer)
      mlpt_pkg::L_ONE: rd_data_r <= feat_mem[rd_addr[FW-1:0]];
      mlpt_pkg::L_TWO: rd_data_r <= h1_mem[rd_addr[HW-1:0]];
      default:         rd_data_r <= h2_mem[rd_addr[HW-1:0]];
    endcase
  end

endmodule

### rtl/core/mlpt_mac.sv
// Digit-serial multiply-accumulate: four bits of the activation per cycle while step is asserted.
module mlpt_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mlpt_pkg::mac_ctrl_t  ctrl,
  input  logic signed [15:0]   w_in,
  input  logic signed [15:0]   x_in,
  output logic                 dig_last,
  output logic signed [15:0]   y
);

  logic signed [39:0] acc_r, acc_nxt;
  logic signed [15:0] w_r;
  logic [15:0]        x_sr_r;
  logic [1:0]         dig_r;
  logic signed [4:0]  digit;
  logic signed [20:0] prod;
  logic signed [39:0] shifted;
  logic signed [27:0] r;

  always_comb begin
    // top digit carries the sign of the activation
    digit   = (dig_r == 2'd3) ? $signed({x_sr_r[3], x_sr_r[3:0]})
                              : $signed({1'b0, x_sr_r[3:0]});
    prod    = w_r * digit;
    shifted = $signed({{19{prod[20]}}, prod}) <<< {dig_r, 2'b00};
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.step) begin
      acc_nxt = acc_r + shifted;
    end else if (ctrl.bias) begin
      acc_nxt = acc_r + $signed({{12{w_in[15]}}, w_in, 12'd0})
                + 40'sd2048;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      dig_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (ctrl.load) begin
        dig_r <= '0;
      end else if (ctrl.step) begin
        dig_r <= dig_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      w_r    <= w_in;
      x_sr_r <= x_in;
    end else if (ctrl.step) begin
      x_sr_r <= {4'd0, x_sr_r[15:4]};
    end
  end

  assign dig_last = (dig_r == 2'd3);

  // floor shift, then saturate to 16 bits
  always_comb begin
    r = acc_r[39:mlpt_pkg::FRAC_BITS];
    if (r > 28'sd32767) begin
      y = 16'sh7fff;
    end else if (r < -28'sd32768) begin
      y = -16'sh8000;
    end else begin
      y = r[15:0];
    end
  end

endmodule

### rtl/core/mlpt_tanh.sv
// Tanh lookup: hidden activation and motor thrust, two register stages.
module mlpt_tanh #(
  parameter int TANH_TABLE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic signed [15:0]   x,
  output logic signed [15:0]   act,
  output logic [15:0]          thrust
);

  localparam int KW = $clog2(TANH_TABLE_ENTRIES);

  typedef logic [16:0] rom_t [TANH_TABLE_ENTRIES];

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t build_rom();
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] q2;
    logic [63:0] y;
    logic [63:0] num;
    logic [63:0] den;
    rom_t        t;
    a    = (64'd8 << 30) / TANH_TABLE_ENTRIES;
    term = 64'd1 << 30;
    q    = 64'd1 << 30;
    for (int n = 1; n <= 14; n++) begin
      term = udiv((term * a) >> 30, 64'(n));
      if (n % 2 == 1) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    q2 = (q * q) >> 30;
    y  = q;
    for (int k = 0; k < TANH_TABLE_ENTRIES; k++) begin
      num  = ((64'd1 << 30) - y) << 16;
      den  = (64'd1 << 30) + y;
      t[k] = 17'(udiv(num + (den >> 1), den));
      y    = (y * q2) >> 30;
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [16:0]    mag;
  logic [31:0]    kprod;
  logic [KW-1:0]  k;
  logic [KW-1:0]  k_r;
  logic           neg_r, neg2_r;
  logic [16:0]    m_r;
  logic [17:0]    rnd;
  logic [17:0]    u;
  logic [32:0]    tprod;

  always_comb begin
    mag   = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
    kprod = 32'(mag) * 32'(TANH_TABLE_ENTRIES);
    if ((kprod >> 15) > 32'(TANH_TABLE_ENTRIES - 1)) begin
      k = KW'(TANH_TABLE_ENTRIES - 1);
    end else begin
      k = KW'(kprod >> 15);
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k;
    neg_r  <= x[15];
    m_r    <= ROM[k_r];
    neg2_r <= neg_r;
  end

  always_comb begin
    rnd    = (18'(m_r) + 18'd8) >> 4;
    act    = neg2_r ? -$signed(rnd[15:0]) : $signed(rnd[15:0]);
    u      = neg2_r ? (18'd65536 - 18'(m_r)) : (18'd65536 + 18'(m_r));
    tprod  = 33'(u) * 33'(mlpt_pkg::FULL_SCALE);
    thrust = tprod[31:16];
  end

endmodule

### rtl/core/mlp_tanh_policy_inference.sv
// Three-layer tanh perceptron on one shared digit-serial MAC.
// Load and feature beats are accepted only while idle; a feature beat with tlast runs a pass.
// Each weight steps through fetch, load and four 4-bit digits of the shared MAC;
// each neuron then passes bias read, bias add, activation, tanh lookup and put.
// Results leave through an output register; the pass stalls while it is full.
// Synchronous active-low reset clears sequencer, accumulator and output valid.
module mlp_tanh_policy_inference #(
  parameter int INPUT_COUNT        = 18,
  parameter int HIDDEN_COUNT       = 64,
  parameter int OUTPUT_COUNT       = 8,
  parameter int EMITTED_COUNT      = 4,
  parameter int TANH_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // index[12:0], value[28:13], zero pad
  input  logic [0:0]  in_tuser,   // opcode[0]
  input  logic        in_tlast,   // start_inference
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // action_value[15:0], thrust[31:16]
  output logic [1:0]  out_tuser,  // motor_index[1:0]
  output logic        out_tlast   // last_result
);

  localparam int B0_BASE     = HIDDEN_COUNT * INPUT_COUNT;
  localparam int W1_BASE     = B0_BASE + HIDDEN_COUNT;
  localparam int B1_BASE     = W1_BASE + HIDDEN_COUNT * HIDDEN_COUNT;
  localparam int W2_BASE     = B1_BASE + HIDDEN_COUNT;
  localparam int B2_BASE     = W2_BASE + OUTPUT_COUNT * HIDDEN_COUNT;
  localparam int STORE_DEPTH = B2_BASE + OUTPUT_COUNT;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int EMIT_N      = (EMITTED_COUNT < OUTPUT_COUNT) ? EMITTED_COUNT : OUTPUT_COUNT;
  localparam int MAXF        = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT;
  localparam int JW          = $clog2(MAXF + 1);
  localparam int NCNT        = (HIDDEN_COUNT > EMIT_N) ? HIDDEN_COUNT : EMIT_N;
  localparam int NW          = $clog2(NCNT + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FETCH = 10'b0000000010,
    S_LOAD  = 10'b0000000100,
    S_MAC   = 10'b0000001000,
    S_BRD   = 10'b0000010000,
    S_BIAS  = 10'b0000100000,
    S_ACT   = 10'b0001000000,
    S_TK    = 10'b0010000000,
    S_TM    = 10'b0100000000,
    S_PUT   = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  mlpt_pkg::layer_t   layer_r, layer_nxt;
  logic [JW-1:0]      j_r, j_nxt;
  logic [NW-1:0]      i_r, i_nxt;
  logic [AW-1:0]      w_addr_r, w_addr_nxt;
  logic [AW-1:0]      b_addr_r, b_addr_nxt;
  logic signed [15:0] y_r;

  logic               out_tvalid_r;
  logic [31:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;
  logic               out_tlast_r;

  logic               in_acc, start, st_wr, ft_wr;
  logic [12:0]        in_index;
  logic signed [15:0] in_value;
  logic signed [15:0] st_rdata, buf_rdata, mac_y, act;
  logic [15:0]        thrust;
  logic               dig_last, out_free, out_load, hid_wr;
  logic               last_j, last_i;
  int                 fanin, ncount;
  mlpt_pkg::mac_ctrl_t mctrl;

  assign in_index = in_tdata[12:0];
  assign in_value = in_tdata[28:13];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign st_wr    = in_acc && !in_tuser[0] && (32'(in_index) < STORE_DEPTH);
  assign ft_wr    = in_acc && in_tuser[0];
  assign start    = in_acc && in_tuser[0] && in_tlast;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    fanin  = (layer_r == mlpt_pkg::L_ONE) ? INPUT_COUNT : HIDDEN_COUNT;
    ncount = (layer_r == mlpt_pkg::L_OUT) ? EMIT_N : HIDDEN_COUNT;
    last_j = (32'(j_r) == fanin - 1);
    last_i = (32'(i_r) == ncount - 1);
  end

  mlpt_wstore #(.DEPTH(STORE_DEPTH), .AW(AW)) u_wstore (
    .clk       (clk),
    .wr_en     (st_wr),
    .wr_addr   (AW'(in_index)),
    .wr_data   (in_value),
    .rd_addr   ((state_r == S_BRD) ? b_addr_r : w_addr_r),
    .rd_data_r (st_rdata)
  );

  mlpt_abuf #(
    .INPUT_COUNT(INPUT_COUNT), .HIDDEN_COUNT(HIDDEN_COUNT), .JW(JW), .NW(NW)
  ) u_abuf (
    .clk       (clk),
    .layer     (layer_r),
    .rd_addr   (j_r),
    .rd_data_r (buf_rdata),
    .feat_wr   (ft_wr),
    .feat_addr (in_index),
    .feat_data (in_value),
    .hid_wr    (hid_wr),
    .hid_addr  (i_r),
    .hid_data  (act)
  );

  mlpt_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mctrl),
    .w_in     (st_rdata),
    .x_in     (buf_rdata),
    .dig_last (dig_last),
    .y        (mac_y)
  );

  mlpt_tanh #(.TANH_TABLE_ENTRIES(TANH_TABLE_ENTRIES)) u_tanh (
    .clk    (clk),
    .x      (y_r),
    .act    (act),
    .thrust (thrust)
  );

  always_comb begin
    state_nxt  = state_r;
    layer_nxt  = layer_r;
    j_nxt      = j_r;
    i_nxt      = i_r;
    w_addr_nxt = w_addr_r;
    b_addr_nxt = b_addr_r;
    mctrl      = '0;
    hid_wr     = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          layer_nxt  = mlpt_pkg::L_ONE;
          i_nxt      = '0;
          j_nxt      = '0;
          w_addr_nxt = '0;
          b_addr_nxt = AW'(B0_BASE);
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD: begin
        mctrl.load  = 1'b1;
        mctrl.clear = (j_r == '0);
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        mctrl.step = 1'b1;
        if (dig_last) begin
          w_addr_nxt = w_addr_r + AW'(1);
          if (last_j) begin
            j_nxt     = '0;
            state_nxt = S_BRD;
          end else begin
            j_nxt     = j_r + JW'(1);
            state_nxt = S_FETCH;
          end
        end
      end
      S_BRD:  state_nxt = S_BIAS;
      S_BIAS: begin
        mctrl.bias = 1'b1;
        state_nxt  = S_ACT;
      end
      S_ACT:  state_nxt = S_TK;
      S_TK:   state_nxt = S_TM;
      S_TM:   state_nxt = S_PUT;
      S_PUT: begin
        hid_wr   = (layer_r != mlpt_pkg::L_OUT);
        out_load = (layer_r == mlpt_pkg::L_OUT) && out_free;
        if (hid_wr || out_load) begin
          b_addr_nxt = b_addr_r + AW'(1);
          state_nxt  = S_FETCH;
          if (last_i) begin
            i_nxt = '0;
            case (layer_r)
              mlpt_pkg::L_ONE: begin
                layer_nxt  = mlpt_pkg::L_TWO;
                w_addr_nxt = AW'(W1_BASE);
                b_addr_nxt = AW'(B1_BASE);
              end
              mlpt_pkg::L_TWO: begin
                layer_nxt  = mlpt_pkg::L_OUT;
                w_addr_nxt = AW'(W2_BASE);
                b_addr_nxt = AW'(B2_BASE);
              end
              default: state_nxt = S_IDLE;
            endcase
          end else begin
            i_nxt = i_r + NW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      layer_r      <= mlpt_pkg::L_ONE;
      j_r          <= '0;
      i_r          <= '0;
      w_addr_r     <= '0;
      b_addr_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      layer_r  <= layer_nxt;
      j_r      <= j_nxt;
      i_r      <= i_nxt;
      w_addr_r <= w_addr_nxt;
      b_addr_r <= b_addr_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ACT) begin
      y_r <= mac_y;
    end
    if (out_load) begin
      out_tdata_r <= {thrust, y_r};
      out_tuser_r <= 2'(i_r);
      out_tlast_r <= last_i;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

### rtl/core/mlpt_checker.sv
// Port-level checks for the perceptron inference block, bound to the top level.
module mlpt_checker #(
  parameter int OUTPUT_COUNT  = 8,
  parameter int EMITTED_COUNT = 4
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  localparam int EMIT_N = (EMITTED_COUNT < OUTPUT_COUNT) ? EMITTED_COUNT : OUTPUT_COUNT;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] && in_tlast |=> !in_tready)
    else $error("input still ready after a pass started");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == 2'(EMIT_N - 1))
    else $error("last result carries the wrong motor index");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind mlp_tanh_policy_inference mlpt_checker #(
  .OUTPUT_COUNT(OUTPUT_COUNT), .EMITTED_COUNT(EMITTED_COUNT)
) u_mlpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### tb/tb_mlp_tanh_policy_inference.sv
// Self-checking testbench for the tanh perceptron inference block.
`timescale 1ns / 1ps

module tb_mlp_tanh_policy_inference;

  localparam int NIN = 18;
  localparam int NHID = 64;
  localparam int NOUT = 8;
  localparam int NEMIT = 4;
  localparam int TANH_ENTRIES = 256;
  localparam int W0_BASE = 0;
  localparam int B0_BASE = W0_BASE + NHID * NIN;
  localparam int W1_BASE = B0_BASE + NHID;
  localparam int B1_BASE = W1_BASE + NHID * NHID;
  localparam int W2_BASE = B1_BASE + NHID;
  localparam int B2_BASE = W2_BASE + NOUT * NHID;
  localparam int STORE_WORDS = B2_BASE + NOUT;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  typedef struct {
    logic [1:0]        motor;
    logic signed [15:0] action;
    logic [15:0]       thrust;
    logic              last;
  } motor_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // index[12:0], value[28:13], zero pad
  logic [0:0]  in_tuser;   // opcode[0]
  logic        in_tlast;   // start_inference
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // action_value[15:0], thrust[31:16]
  logic [1:0]  out_tuser;  // motor_index[1:0]
  logic        out_tlast;  // last_result

  mlp_tanh_policy_inference i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predictor state
  logic signed [15:0] weight_mem [0:STORE_WORDS-1];
  logic signed [15:0] feature_mem [0:NIN-1];
  logic signed [15:0] layer_in [0:NHID-1];
  logic signed [15:0] hidden_one [0:NHID-1];
  logic signed [15:0] hidden_two [0:NHID-1];
  logic signed [15:0] action_out [0:NOUT-1];
  longint             tanh_mag [0:TANH_ENTRIES-1];
  motor_result_t      pending_actions [$];

  int  errors = 0;
  int  passes_run = 0;
  int  hold_cycles = 0;
  bit  no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #150_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void build_tanh_table();
    longint one, a, term, q, q2, y, num, den;
    one = longint'(1) << 30;
    a = (longint'(8) << 30) / TANH_ENTRIES;
    term = one;
    q = one;
    for (int n = 1; n <= 14; n++) begin
      term = (term * a) / one / n;
      if (n % 2 == 1) q = q - term;
      else q = q + term;
    end
    q2 = (q * q) / one;
    y = q;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      num = (one - y) * 65536;
      den = one + y;
      tanh_mag[k] = (num + den / 2) / den;
      y = (y * q2) / one;
    end
  endfunction

  function automatic longint tanh_q16(int x);
    longint mag, k;
    mag = (x < 0) ? -x : x;
    k = (mag * TANH_ENTRIES) >>> 15;
    if (k > TANH_ENTRIES - 1) k = TANH_ENTRIES - 1;
    return (x < 0) ? -tanh_mag[k] : tanh_mag[k];
  endfunction

  function automatic logic signed [15:0] squash(logic signed [15:0] x);
    longint t, m, r;
    t = tanh_q16(int'(x));
    m = (t < 0) ? -t : t;
    r = (m + 8) >>> 4;
    return 16'(t < 0 ? -r : r);
  endfunction

  // Weighted sum over layer_in plus bias, rounded and saturated to Q3.12.
  function automatic logic signed [15:0] neuron_sum(int wbase, int baddr, int fanin);
    longint acc, v, r;
    acc = 0;
    for (int j = 0; j < fanin; j++)
      acc += longint'(weight_mem[wbase + j]) * longint'(layer_in[j]);
    acc += longint'(weight_mem[baddr]) * 4096;
    v = acc + 2048;
    if (v >= 0) r = v / 4096;
    else r = -((-v + 4095) / 4096);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic void predict_actions();
    motor_result_t res;
    longint s;
    for (int j = 0; j < NIN; j++) layer_in[j] = feature_mem[j];
    for (int i = 0; i < NHID; i++)
      hidden_one[i] = squash(neuron_sum(W0_BASE + i * NIN, B0_BASE + i, NIN));
    for (int j = 0; j < NHID; j++) layer_in[j] = hidden_one[j];
    for (int i = 0; i < NHID; i++)
      hidden_two[i] = squash(neuron_sum(W1_BASE + i * NHID, B1_BASE + i, NHID));
    for (int j = 0; j < NHID; j++) layer_in[j] = hidden_two[j];
    for (int i = 0; i < NOUT; i++)
      action_out[i] = neuron_sum(W2_BASE + i * NHID, B2_BASE + i, NHID);
    for (int k = 0; k < NEMIT; k++) begin
      s = tanh_q16(int'(action_out[k]));
      res.motor = 2'(k);
      res.action = action_out[k];
      res.thrust = 16'(((65536 + s) * mlpt_pkg::FULL_SCALE) >>> 16);
      res.last = (k == NEMIT - 1);
      pending_actions.push_back(res);
    end
    passes_run++;
  endfunction

  function automatic void apply_beat(logic op, int idx, logic signed [15:0] val, logic start);
    if (op == OP_LOAD) begin
      if (idx < STORE_WORDS) weight_mem[idx] = val;
    end else begin
      if (idx < NIN) feature_mem[idx] = val;
      if (start) predict_actions();
    end
  endfunction

  // Drive one beat from the falling edge; return at a falling edge with tvalid held.
  task automatic send_beat(logic op, int idx, logic signed [15:0] val, logic start);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {3'b000, val, idx[12:0]};
    in_tuser = op;
    in_tlast = start;
    do @(posedge clk); while (!in_tready);
    apply_beat(op, idx, val, start);
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_tvalid = 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_weight();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1536) - 768);
  endfunction

  function automatic logic signed [15:0] rand_feature();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8192) - 4096);
  endfunction

  // Receiver: ready changes at the falling edge
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready = 1'b0;
      end else begin
        out_tready = no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin
    motor_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_actions.size() == 0) begin
          $display("%0t: unexpected beat motor=%0d action=%0d thrust=%0d last=%0b",
                   $time, out_tuser, $signed(out_tdata[15:0]), out_tdata[31:16], out_tlast);
          errors++;
        end else begin
          want = pending_actions.pop_front();
          if (out_tuser !== want.motor) begin
            $display("%0t: motor_index expected %0d actual %0d", $time, want.motor, out_tuser);
            errors++;
          end
          if (out_tdata[15:0] !== want.action) begin
            $display("%0t: action_value expected %0d actual %0d", $time, want.action,
                     $signed(out_tdata[15:0]));
            errors++;
          end
          if (out_tdata[31:16] !== want.thrust) begin
            $display("%0t: thrust expected %0d actual %0d", $time, want.thrust,
                     out_tdata[31:16]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_result expected %0b actual %0b", $time, want.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Fill every store word, extremes included; the first half runs without gaps.
  task automatic test_weight_load();
    logic signed [15:0] w;
    for (int a = 0; a < STORE_WORDS; a++) begin
      no_idle = (a < STORE_WORDS / 2);
      if (a == 0) w = 16'sh7fff;
      else if (a == 1) w = 16'sh8000;
      else w = rand_weight();
      send_beat(OP_LOAD, a, w, 1'b0);
    end
    no_idle = 0;
  endtask

  // Ignored writes: addresses past the store, positions past the buffer, start on a load.
  task automatic test_ignored_writes();
    send_beat(OP_LOAD, 8191, 16'sh7fff, 1'b0);
    send_beat(OP_LOAD, STORE_WORDS, 16'sh8000, 1'b1);
    send_beat(OP_LOAD, STORE_WORDS - 1, 16'sh0100, 1'b1);
    send_beat(OP_FEATURE, NIN, 16'sh7fff, 1'b0);
    send_beat(OP_FEATURE, 8191, 16'sh8000, 1'b0);
  endtask

  // Write all features with extremes, then run passes, one started from a bad position.
  task automatic test_first_passes();
    for (int p = 0; p < NIN; p++)
      send_beat(OP_FEATURE, p, (p == 0) ? 16'sh7fff : (p == 1) ? 16'sh8000 : rand_feature(),
                p == NIN - 1);
    send_beat(OP_FEATURE, 0, 16'sh0000, 1'b1);
    send_beat(OP_FEATURE, 4095, 16'sh1234, 1'b1);
    go_quiet();
  endtask

  // Hold the receiver off past a full pass so the output fills and input stalls.
  task automatic test_backpressure();
    hold_cycles = 45000;
    send_beat(OP_FEATURE, 3, rand_feature(), 1'b1);
    for (int n = 0; n < 4; n++) send_beat(OP_LOAD, $urandom_range(0, STORE_WORDS - 1),
                                          rand_weight(), 1'b0);
    no_idle = 1;
    go_quiet();
    no_idle = 0;
  endtask

  task automatic test_random_mix();
    int beats;
    int sel;
    beats = 0;
    while (beats < 480 || passes_run < 12) begin
      sel = $urandom_range(0, 99);
      if (sel < 55)
        send_beat(OP_LOAD,
                  (sel < 5) ? $urandom_range(0, 8191) : $urandom_range(0, STORE_WORDS - 1),
                  rand_weight(), 1'($urandom));
      else if (sel < 62)
        send_beat(OP_FEATURE, $urandom_range(0, 8191), rand_feature(), 1'b0);
      else
        send_beat(OP_FEATURE, $urandom_range(0, NIN - 1), rand_feature(),
                  (beats >= 480) || ($urandom_range(0, 15) == 0));
      beats++;
      if (beats == 240) go_quiet();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    build_tanh_table();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_weight_load();
    test_ignored_writes();
    test_first_passes();
    test_backpressure();
    test_random_mix();
    go_quiet();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
